>>> hdl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and defaults of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Default arena geometry.
  localparam int ARENA_BYTES_DEF        = 65536;
  localparam int HEADER_BYTES_DEF       = 16;
  localparam int FIRST_HEADER_BYTES_DEF = 24;
  localparam int ALIGN_BYTES_DEF        = 8;

  // Fixed field widths.
  localparam int CFG_W      = 17;
  localparam int REQ_W      = 16;
  localparam int OFFS_W     = 16;
  localparam int ARENA_MIN  = 64;

  // Request codes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  // Result codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_BLOCK = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [REQ_W-1:0]    request_bytes;
    logic [OFFS_W-1:0]   block_offset;
  } in_t;

  typedef struct packed {
    logic [OFFS_W-1:0]   data_offset;
    status_t             status;
  } out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_MUL,
    S_WALK,
    S_SPLIT,
    S_FNEXT,
    S_RESP
  } fsm_t;

  // Largest power-of-two exponent, at most 6, that divides every header offset.
  function automatic int gran_shift(int a, int b, int c);
    int v;
    int s;
    v = a | b | c;
    s = 0;
    for (int i = 1; i <= 6; i++) begin
      if ((v & ((1 << i) - 1)) == 0) s = i;
    end
    return s;
  endfunction

endpackage

>>> hdl/ffba_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffba_hdr_mem
// Block header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_hdr_mem #(
  parameter int DEPTH = 8193,
  parameter int IW    = 14,
  parameter int DW    = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [IW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Walks the implicit block list in the header store, allocates, frees and
// merges, and produces one result per request.
// ----------------------------------------------------------------------------
module ffba_ctrl #(
  parameter int ARENA_BYTES        = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES       = ffba_pkg::HEADER_BYTES_DEF,
  parameter int FIRST_HEADER_BYTES = ffba_pkg::FIRST_HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES        = ffba_pkg::ALIGN_BYTES_DEF,
  parameter int AW                 = 17,
  parameter int IW                 = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffba_pkg::in_t  in_data,
  input  logic [AW-1:0]  arena,
  input  logic           cfg_we,
  output logic           res_valid,
  input  logic           res_ready,
  output ffba_pkg::out_t res_data,
  output logic           mem_we,
  output logic [IW-1:0]  mem_waddr,
  output logic [AW:0]    mem_wdata,
  output logic [IW-1:0]  mem_raddr,
  input  logic [AW:0]    mem_rdata
);

  localparam int GSH   = ffba_pkg::gran_shift(ALIGN_BYTES, HEADER_BYTES, FIRST_HEADER_BYTES);
  localparam int OW0   = $clog2(ARENA_BYTES + FIRST_HEADER_BYTES + 2 * HEADER_BYTES + 1);
  localparam int OW    = (OW0 > 18) ? OW0 : 18;
  localparam int NW    = ffba_pkg::REQ_W + 1;
  localparam int RSH   = 24;
  localparam longint RCP_VAL = ((64'd1 << RSH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam logic [RSH:0] RCP = (RSH+1)'(RCP_VAL);
  localparam logic [OW-1:0] HDR = OW'(HEADER_BYTES);
  localparam logic [OW-1:0] FHDR = OW'(FIRST_HEADER_BYTES);

  ffba_pkg::fsm_t state, state_next;

  // Request and walk registers.
  ffba_pkg::opcode_t op;
  logic [NW-1:0]     numer;
  logic [NW-1:0]     quot;
  logic [NW-1:0]     sz;
  logic [ffba_pkg::OFFS_W-1:0] target;
  logic [OW-1:0]     off;
  logic [OW-1:0]     prev_off;
  logic              prev_free;
  logic [AW-1:0]     prev_size;
  logic [AW-1:0]     cur_size;
  logic [ffba_pkg::OFFS_W-1:0] res_off;
  ffba_pkg::status_t res_status;

  // Header just read.
  logic          hdr_free;
  logic [AW-1:0] hdr_size;
  logic [OW-1:0] next_off;
  logic          last;
  logic          fit;
  logic          split;
  logic          hit;
  logic          passed;
  logic [OW-1:0] merged;
  logic [OW-1:0] init_size;
  logic [2*NW+RSH:0] prod;

  assign hdr_free  = mem_rdata[AW];
  assign hdr_size  = mem_rdata[AW-1:0];
  assign next_off  = off + OW'(hdr_size) + HDR;
  assign last      = next_off >= (OW'(arena) + HDR);
  assign fit       = hdr_free && (OW'(hdr_size) >= OW'(sz));
  assign split     = OW'(hdr_size) >= (OW'(sz) + HDR);
  assign hit       = off == OW'(target);
  assign passed    = off > OW'(target);
  assign init_size = (OW'(arena) > FHDR) ? (OW'(arena) - FHDR) : '0;
  assign prod      = (2*NW+RSH+1)'(numer) * (2*NW+RSH+1)'(RCP);

  // Size of the freed block after absorbing a free successor.
  always_comb begin
    if (state == ffba_pkg::S_FNEXT) begin
      merged = OW'(cur_size) + (hdr_free ? (OW'(hdr_size) + HDR) : '0);
    end else begin
      merged = OW'(hdr_size);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ffba_pkg::S_INIT:  state_next = ffba_pkg::S_IDLE;
      ffba_pkg::S_IDLE:  if (in_valid) state_next = ffba_pkg::S_DIV;
      ffba_pkg::S_DIV:   state_next = ffba_pkg::S_MUL;
      ffba_pkg::S_MUL:   state_next = ffba_pkg::S_WALK;
      ffba_pkg::S_WALK: begin
        if (op == ffba_pkg::OP_ALLOC) begin
          if (fit) state_next = split ? ffba_pkg::S_SPLIT : ffba_pkg::S_RESP;
          else if (last) state_next = ffba_pkg::S_RESP;
        end else begin
          if (hit) begin
            state_next = (hdr_free || last) ? ffba_pkg::S_RESP : ffba_pkg::S_FNEXT;
          end else if (last || passed) begin
            state_next = ffba_pkg::S_RESP;
          end
        end
      end
      ffba_pkg::S_SPLIT: state_next = ffba_pkg::S_RESP;
      ffba_pkg::S_FNEXT: state_next = ffba_pkg::S_RESP;
      ffba_pkg::S_RESP:  if (res_ready) state_next = ffba_pkg::S_IDLE;
      default:           state_next = ffba_pkg::S_INIT;
    endcase
    if (cfg_we) state_next = ffba_pkg::S_INIT;
  end

  // Outputs: handshake, memory ports.
  always_comb begin
    in_ready  = state == ffba_pkg::S_IDLE;
    res_valid = state == ffba_pkg::S_RESP;
    mem_we    = 1'b0;
    mem_waddr = IW'(off >> GSH);
    mem_wdata = '0;
    mem_raddr = IW'(off >> GSH);
    unique case (state)
      ffba_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(FHDR >> GSH);
        mem_wdata = {1'b1, AW'(init_size)};
      end
      ffba_pkg::S_MUL: mem_raddr = IW'(FHDR >> GSH);
      ffba_pkg::S_WALK: begin
        mem_raddr = IW'(next_off >> GSH);
        if (op == ffba_pkg::OP_ALLOC) begin
          if (fit) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, split ? AW'(sz) : hdr_size};
          end
        end else if (hit && !hdr_free && last) begin
          mem_we    = 1'b1;
          mem_waddr = IW'((prev_free ? prev_off : off) >> GSH);
          mem_wdata = {1'b1, prev_free ? AW'(OW'(prev_size) + merged + HDR) : AW'(merged)};
        end
      end
      ffba_pkg::S_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = IW'((off + OW'(sz) + HDR) >> GSH);
        mem_wdata = {1'b1, AW'(OW'(cur_size) - OW'(sz) - HDR)};
      end
      ffba_pkg::S_FNEXT: begin
        mem_we    = 1'b1;
        mem_waddr = IW'((prev_free ? prev_off : off) >> GSH);
        mem_wdata = {1'b1, prev_free ? AW'(OW'(prev_size) + merged + HDR) : AW'(merged)};
      end
      default: ;
    endcase
  end

  assign res_data.data_offset = res_off;
  assign res_data.status      = res_status;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ffba_pkg::S_INIT;
    else     state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ffba_pkg::S_IDLE: begin
        op     <= in_data.opcode;
        numer  <= NW'(in_data.request_bytes) + NW'(ALIGN_BYTES - 1);
        target <= in_data.block_offset;
      end
      ffba_pkg::S_DIV: quot <= NW'(prod >> RSH);
      ffba_pkg::S_MUL: begin
        sz        <= NW'(quot * NW'(ALIGN_BYTES));
        off       <= FHDR;
        prev_free <= 1'b0;
      end
      ffba_pkg::S_WALK: begin
        cur_size   <= hdr_size;
        res_off    <= '0;
        res_status <= ffba_pkg::ST_OK;
        if (op == ffba_pkg::OP_ALLOC) begin
          if (fit) res_off <= off[ffba_pkg::OFFS_W-1:0];
          else if (last) res_status <= ffba_pkg::ST_NO_FIT;
        end else if (!hit && (last || passed)) begin
          res_status <= ffba_pkg::ST_NO_BLOCK;
        end
        // Step to the next header while the search goes on.
        if (state_next == ffba_pkg::S_WALK) begin
          prev_off  <= off;
          prev_free <= hdr_free;
          prev_size <= hdr_size;
          off       <= next_off;
        end
      end
      default: ;
    endcase
  end

  // A new request always starts with the rounding step.
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !cfg_we) |=> state == ffba_pkg::S_DIV)
    else $error("accepted request did not start rounding");

  // A tail header is only written right after the fitting block was found.
  a_split_order: assert property (@(posedge clk) disable iff (rst)
    state == ffba_pkg::S_SPLIT |-> $past(state) == ffba_pkg::S_WALK)
    else $error("split without a preceding walk");

  // The walk never leaves the arena; an empty last block sits at its end.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ffba_pkg::S_WALK |-> off <= OW'(arena))
    else $error("header walk passed the arena end");

  // The header store is written only by the states that own a write.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ffba_pkg::S_INIT || state == ffba_pkg::S_WALK ||
                state == ffba_pkg::S_SPLIT || state == ffba_pkg::S_FNEXT))
    else $error("header write in an unexpected state");

endmodule

>>> hdl/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over an arena kept as an implicit list of block headers.
//
//   Port group   Direction  Handshake            Payload
//   in_*         input      in_valid / in_stall  ffba_pkg::in_t
//   out_*        output     out_valid / out_stall ffba_pkg::out_t
//   cfg_*        input      cfg_we               arena length, 17 bits
//
// A request is rounded in DIV and MUL, walks the headers from the arena start
// in WALK (one header per cycle through the header store read port) and hands
// over its result in RESP; a split, or freeing an allocated block that is not
// the last one, adds a SPLIT or FNEXT state. Reset and every arena write pass
// through INIT, which writes the single free block header. out_stall holds the
// result in the output register while the next request is already in progress.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
  parameter int ARENA_BYTES        = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES       = ffba_pkg::HEADER_BYTES_DEF,
  parameter int FIRST_HEADER_BYTES = ffba_pkg::FIRST_HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES        = ffba_pkg::ALIGN_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ffba_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ffba_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [ffba_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int AW        = $clog2(ARENA_BYTES + 1);
  localparam int GSH       = ffba_pkg::gran_shift(ALIGN_BYTES, HEADER_BYTES, FIRST_HEADER_BYTES);
  localparam int DEPTH     = (ARENA_BYTES >> GSH) + 1;
  localparam int IW        = $clog2(DEPTH);
  localparam int ARENA_RST = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;

  logic [AW-1:0]  arena;
  logic [31:0]    wv;
  logic [AW-1:0]  arena_clamped;
  logic           in_ready;
  logic           res_valid;
  logic           res_ready;
  ffba_pkg::out_t res_data;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [AW:0]    mem_wdata;
  logic [IW-1:0]  mem_raddr;
  logic [AW:0]    mem_rdata;

  // Saturate the written arena length into its legal range.
  always_comb begin
    wv = 32'(cfg_wdata);
    if (wv < 32'(ffba_pkg::ARENA_MIN))  arena_clamped = AW'(ffba_pkg::ARENA_MIN);
    else if (wv > 32'(ARENA_BYTES))      arena_clamped = AW'(ARENA_BYTES);
    else                                 arena_clamped = AW'(wv);
  end

  always_ff @(posedge clk) begin
    if (rst)         arena <= AW'(ARENA_RST);
    else if (cfg_we) arena <= arena_clamped;
  end

  assign in_stall  = !in_ready;
  assign res_ready = !out_valid || !out_stall;

  // Output register decouples the result from the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data <= res_data;
  end

  ffba_ctrl #(
    .ARENA_BYTES        (ARENA_BYTES),
    .HEADER_BYTES       (HEADER_BYTES),
    .FIRST_HEADER_BYTES (FIRST_HEADER_BYTES),
    .ALIGN_BYTES        (ALIGN_BYTES),
    .AW                 (AW),
    .IW                 (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .arena     (arena),
    .cfg_we    (cfg_we),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ffba_hdr_mem #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .DW    (AW + 1)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
